@@ rtl/qpt_pkg.sv @@
// Shared constants and register codes for the quaternion point transform.
package qpt_pkg;

  localparam int POS_WIDTH_DEF   = 24;
  localparam int QUAT_WIDTH_DEF  = 16;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int PIPE_STAGES     = 5;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_QUAT_W   = 3'd0,
    REG_QUAT_X   = 3'd1,
    REG_QUAT_Y   = 3'd2,
    REG_QUAT_Z   = 3'd3,
    REG_CENTER_X = 3'd4,
    REG_CENTER_Y = 3'd5,
    REG_CENTER_Z = 3'd6
  } cfg_reg_t;

endpackage

@@ rtl/quaternion_point_transform_top.sv @@
// A result strobes on done once its start word, when taken, has passed all the pipeline stages.
// Throughput: one point per cycle; the five-stage multiply pipeline never stalls.
// Reset clears the pipeline valid bits and loads the identity-like quaternion
// (w just below one, vector part zero) and a zero offset; busy is high only in reset.
// Top level of the quaternion point transform.
module quaternion_point_transform_top #(
  parameter int POS_WIDTH  = qpt_pkg::POS_WIDTH_DEF,
  parameter int QUAT_WIDTH = qpt_pkg::QUAT_WIDTH_DEF,
  localparam int CfgWidth  = (POS_WIDTH > QUAT_WIDTH) ? POS_WIDTH : QUAT_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [POS_WIDTH-1:0]         body_x,
  input  logic signed [POS_WIDTH-1:0]         body_y,
  input  logic signed [POS_WIDTH-1:0]         body_z,
  output logic                                done,
  output logic signed [POS_WIDTH-1:0]         world_x,
  output logic signed [POS_WIDTH-1:0]         world_y,
  output logic signed [POS_WIDTH-1:0]         world_z,
  output logic                                saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qpt_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CfgWidth-1:0]                 cfg_data
);

  localparam logic signed [POS_WIDTH-1:0] PosMax = {1'b0, {(POS_WIDTH - 1){1'b1}}};
  localparam logic signed [POS_WIDTH-1:0] PosMin = {1'b1, {(POS_WIDTH - 1){1'b0}}};

  logic signed [QUAT_WIDTH-1:0] quat_w, quat_x, quat_y, quat_z;
  logic signed [POS_WIDTH-1:0]  center_x, center_y, center_z;
  logic                         accept;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_w   <= {1'b0, {(QUAT_WIDTH - 1){1'b1}}};
      quat_x   <= '0;
      quat_y   <= '0;
      quat_z   <= '0;
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (qpt_pkg::cfg_reg_t'(cfg_index))
        qpt_pkg::REG_QUAT_W:   quat_w   <= $signed(cfg_data[QUAT_WIDTH-1:0]);
        qpt_pkg::REG_QUAT_X:   quat_x   <= $signed(cfg_data[QUAT_WIDTH-1:0]);
        qpt_pkg::REG_QUAT_Y:   quat_y   <= $signed(cfg_data[QUAT_WIDTH-1:0]);
        qpt_pkg::REG_QUAT_Z:   quat_z   <= $signed(cfg_data[QUAT_WIDTH-1:0]);
        qpt_pkg::REG_CENTER_X: center_x <= $signed(cfg_data[POS_WIDTH-1:0]);
        qpt_pkg::REG_CENTER_Y: center_y <= $signed(cfg_data[POS_WIDTH-1:0]);
        qpt_pkg::REG_CENTER_Z: center_z <= $signed(cfg_data[POS_WIDTH-1:0]);
        default: ;
      endcase
    end
  end

  qpt_datapath #(
    .POS_WIDTH  (POS_WIDTH),
    .QUAT_WIDTH (QUAT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .body_x    (body_x),
    .body_y    (body_y),
    .body_z    (body_z),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .center_x  (center_x),
    .center_y  (center_y),
    .center_z  (center_z),
    .out_valid (done),
    .world_x   (world_x),
    .world_y   (world_y),
    .world_z   (world_z),
    .saturated (saturated)
  );

`ifndef ASSERT_OFF
  // Every accepted word comes out as a result on done.
  assert property (@(posedge clk) disable iff (rst) accept |-> ##5 done)
    else $error("accepted word did not produce a result");

  assert property (@(posedge clk) disable iff (rst) done |-> $past(accept, 5))
    else $error("result without a matching accepted word");

  // A clipped result must show at least one component at a range limit.
  assert property (@(posedge clk) disable iff (rst)
      done && saturated |-> (world_x == PosMax || world_x == PosMin ||
                             world_y == PosMax || world_y == PosMin ||
                             world_z == PosMax || world_z == PosMin))
    else $error("saturated flag without a clipped component");

  assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");
`endif

endmodule

@@ rtl/qpt_datapath.sv @@
// Five-stage rotation and translation datapath for one point per cycle.
module qpt_datapath #(
  parameter int POS_WIDTH  = qpt_pkg::POS_WIDTH_DEF,
  parameter int QUAT_WIDTH = qpt_pkg::QUAT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic signed [POS_WIDTH-1:0]  body_x,
  input  logic signed [POS_WIDTH-1:0]  body_y,
  input  logic signed [POS_WIDTH-1:0]  body_z,
  input  logic signed [QUAT_WIDTH-1:0] quat_w,
  input  logic signed [QUAT_WIDTH-1:0] quat_x,
  input  logic signed [QUAT_WIDTH-1:0] quat_y,
  input  logic signed [QUAT_WIDTH-1:0] quat_z,
  input  logic signed [POS_WIDTH-1:0]  center_x,
  input  logic signed [POS_WIDTH-1:0]  center_y,
  input  logic signed [POS_WIDTH-1:0]  center_z,
  output logic                         out_valid,
  output logic signed [POS_WIDTH-1:0]  world_x,
  output logic signed [POS_WIDTH-1:0]  world_y,
  output logic signed [POS_WIDTH-1:0]  world_z,
  output logic                         saturated
);

  localparam int P     = POS_WIDTH;
  localparam int Q     = QUAT_WIDTH;
  localparam int F     = Q - 1;
  localparam int SqW   = 2 * Q;
  localparam int ASumW = 2 * Q + 2;
  localparam int AW    = ASumW + 1 - F;
  localparam int PrW   = P + Q;
  localparam int BSumW = P + Q + 3;
  localparam int BW    = BSumW + 1 - F;
  localparam int CSumW = P + Q + 1;
  localparam int CW    = CSumW + 1 - F;
  localparam int ApW   = AW + P;
  localparam int BxW   = BW + Q;
  localparam int WcW   = CW + Q;
  localparam int SW    = P + Q + 7;
  localparam int RW    = SW + 1 - F;
  localparam int TW    = RW + 1;

  localparam logic signed [ASumW:0] HalfA = (ASumW + 1)'(1) << (F - 1);
  localparam logic signed [BSumW:0] HalfB = (BSumW + 1)'(1) << (F - 1);
  localparam logic signed [CSumW:0] HalfC = (CSumW + 1)'(1) << (F - 1);
  localparam logic signed [SW:0]    HalfS = (SW + 1)'(1) << (F - 1);
  localparam logic signed [TW-1:0]  PosMax = (TW'(1) << (P - 1)) - TW'(1);
  localparam logic signed [TW-1:0]  PosMin = -(TW'(1) << (P - 1));

  logic [qpt_pkg::PIPE_STAGES-1:0] vld;

  // Stage 1: all first-level products.
  logic signed [SqW-1:0] sq_w, sq_x, sq_y, sq_z;
  logic signed [PrW-1:0] m_xpx, m_ypy, m_zpz;
  logic signed [PrW-1:0] m_ypz, m_zpy, m_zpx, m_xpz, m_xpy, m_ypx;
  logic signed [P-1:0]   p1_x, p1_y, p1_z;

  always_ff @(posedge clk) begin
    sq_w  <= $signed(quat_w) * $signed(quat_w);
    sq_x  <= $signed(quat_x) * $signed(quat_x);
    sq_y  <= $signed(quat_y) * $signed(quat_y);
    sq_z  <= $signed(quat_z) * $signed(quat_z);
    m_xpx <= $signed(quat_x) * $signed(body_x);
    m_ypy <= $signed(quat_y) * $signed(body_y);
    m_zpz <= $signed(quat_z) * $signed(body_z);
    m_ypz <= $signed(quat_y) * $signed(body_z);
    m_zpy <= $signed(quat_z) * $signed(body_y);
    m_zpx <= $signed(quat_z) * $signed(body_x);
    m_xpz <= $signed(quat_x) * $signed(body_z);
    m_xpy <= $signed(quat_x) * $signed(body_y);
    m_ypx <= $signed(quat_y) * $signed(body_x);
    p1_x  <= body_x;
    p1_y  <= body_y;
    p1_z  <= body_z;
  end

  // Stage 2: scale factor, dot term and cross product, each rounded.
  logic signed [ASumW-1:0] a_sum;
  logic signed [ASumW:0]   a_rnd;
  logic signed [BSumW-1:0] b_sum;
  logic signed [BSumW:0]   b_rnd;
  logic signed [CSumW-1:0] cx_sum, cy_sum, cz_sum;
  logic signed [CSumW:0]   cx_rnd, cy_rnd, cz_rnd;
  logic signed [AW-1:0]    a2;
  logic signed [BW-1:0]    b2;
  logic signed [CW-1:0]    cx2, cy2, cz2;
  logic signed [P-1:0]     p2_x, p2_y, p2_z;

  always_comb begin
    a_sum  = sq_w - sq_x - sq_y - sq_z;
    a_rnd  = a_sum + HalfA;
    b_sum  = (m_xpx + m_ypy + m_zpz) <<< 1;
    b_rnd  = b_sum + HalfB;
    cx_sum = m_ypz - m_zpy;
    cy_sum = m_zpx - m_xpz;
    cz_sum = m_xpy - m_ypx;
    cx_rnd = cx_sum + HalfC;
    cy_rnd = cy_sum + HalfC;
    cz_rnd = cz_sum + HalfC;
  end

  // Taking the upper bits of a two's complement word is a floor shift.
  always_ff @(posedge clk) begin
    a2   <= $signed(a_rnd[ASumW:F]);
    b2   <= $signed(b_rnd[BSumW:F]);
    cx2  <= $signed(cx_rnd[CSumW:F]);
    cy2  <= $signed(cy_rnd[CSumW:F]);
    cz2  <= $signed(cz_rnd[CSumW:F]);
    p2_x <= p1_x;
    p2_y <= p1_y;
    p2_z <= p1_z;
  end

  // Stage 3: second-level products.
  logic signed [ApW-1:0] ap_x, ap_y, ap_z;
  logic signed [BxW-1:0] bv_x, bv_y, bv_z;
  logic signed [WcW-1:0] wc_x, wc_y, wc_z;

  always_ff @(posedge clk) begin
    ap_x <= $signed(a2) * $signed(p2_x);
    ap_y <= $signed(a2) * $signed(p2_y);
    ap_z <= $signed(a2) * $signed(p2_z);
    bv_x <= $signed(b2) * $signed(quat_x);
    bv_y <= $signed(b2) * $signed(quat_y);
    bv_z <= $signed(b2) * $signed(quat_z);
    wc_x <= $signed(quat_w) * $signed(cx2);
    wc_y <= $signed(quat_w) * $signed(cy2);
    wc_z <= $signed(quat_w) * $signed(cz2);
  end

  // Stage 4: sum the three terms and round back to position units.
  logic signed [SW-1:0] s_x, s_y, s_z;
  logic signed [SW:0]   s_rx, s_ry, s_rz;
  logic signed [RW-1:0] r_x, r_y, r_z;

  always_comb begin
    s_x  = ap_x + bv_x + (SW'(wc_x) <<< 1);
    s_y  = ap_y + bv_y + (SW'(wc_y) <<< 1);
    s_z  = ap_z + bv_z + (SW'(wc_z) <<< 1);
    s_rx = s_x + HalfS;
    s_ry = s_y + HalfS;
    s_rz = s_z + HalfS;
  end

  always_ff @(posedge clk) begin
    r_x <= $signed(s_rx[SW:F]);
    r_y <= $signed(s_ry[SW:F]);
    r_z <= $signed(s_rz[SW:F]);
  end

  // Stage 5: add the offset and clip to the position range.
  logic signed [TW-1:0] t_x, t_y, t_z;
  logic [2:0]           hi_clip, lo_clip;

  always_comb begin
    t_x = r_x + center_x;
    t_y = r_y + center_y;
    t_z = r_z + center_z;
    hi_clip = {t_z > PosMax, t_y > PosMax, t_x > PosMax};
    lo_clip = {t_z < PosMin, t_y < PosMin, t_x < PosMin};
  end

  always_ff @(posedge clk) begin
    world_x <= hi_clip[0] ? PosMax[P-1:0] : (lo_clip[0] ? PosMin[P-1:0] : t_x[P-1:0]);
    world_y <= hi_clip[1] ? PosMax[P-1:0] : (lo_clip[1] ? PosMin[P-1:0] : t_y[P-1:0]);
    world_z <= hi_clip[2] ? PosMax[P-1:0] : (lo_clip[2] ? PosMin[P-1:0] : t_z[P-1:0]);
    saturated <= |(hi_clip | lo_clip);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[qpt_pkg::PIPE_STAGES-2:0], in_valid};
    end
  end

  assign out_valid = vld[qpt_pkg::PIPE_STAGES-1];

endmodule
